FILE: src/kdsl_pkg.sv
package kdsl_pkg;

   localparam int unsigned BYTE_W      = 8;
   localparam int unsigned NUM_DIGITS  = 4;
   localparam int unsigned CSR_INDEX_W = 3;

   // configuration register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTON_EVENT   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNIT_RESET     = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_BUTTONS_ENABLE = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_USER   = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DISPLAY_SET    = 3'd4;

   localparam logic [7:0] RESET_BUTTON_EVENT   = 8'd68;
   localparam logic [7:0] RESET_UNIT_RESET     = 8'd70;
   localparam logic [7:0] RESET_BUTTONS_ENABLE = 8'd67;
   localparam logic [7:0] RESET_DISPLAY_USER   = 8'd99;
   localparam logic [7:0] RESET_DISPLAY_SET    = 8'd70;

   // response status
   localparam logic STATUS_OK     = 1'b0;
   localparam logic STATUS_REJECT = 1'b1;

   localparam logic [7:0] DIGIT_ENABLE = 8'h0F;
   localparam logic [7:0] DOT_BIT      = 8'h10;

   localparam logic [7:0] CHAR_SPACE   = 8'h20;
   localparam logic [7:0] CHAR_ZERO    = 8'h30;
   localparam logic [7:0] CHAR_NINE    = 8'h39;
   localparam logic [7:0] CHAR_UPPER_A = 8'h41;
   localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
   localparam logic [7:0] CHAR_LOWER_A = 8'h61;
   localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;
   localparam logic [7:0] LETTER_BASE  = 8'd10;

   localparam logic [3:0] LEN_MAX      = 4'd5;
   localparam logic [3:0] LEN_WITH_DOT = 4'd5;

   // digits 0-9 then letters A-Z
   localparam logic [7:0] SEG_TABLE [36] = '{
      8'he7, 8'h06, 8'hcb, 8'h8f, 8'h2e, 8'had, 8'hed, 8'h86, 8'hef, 8'haf,
      8'hee, 8'h6d, 8'h49, 8'h4f, 8'he9, 8'he8, 8'he5, 8'h6e, 8'h06, 8'h47,
      8'h6e, 8'h61, 8'he6, 8'h4c, 8'he7, 8'hea, 8'hae, 8'hee, 8'had, 8'h69,
      8'h45, 8'h67, 8'h67, 8'h6e, 8'h2f, 8'hcb
   };

   typedef enum logic [1:0] {
      OP_RX_BYTE = 2'd0,
      OP_DISPLAY = 2'd1,
      OP_INIT    = 2'd2
   } opcode_type;

   typedef enum logic [1:0] {
      CMD_NONE    = 2'd0,
      CMD_DISPLAY = 2'd1,
      CMD_INIT    = 2'd2
   } cmd_kind_type;

   // one queued command; digits[0] is the rightmost digit
   typedef struct packed {
      cmd_kind_type                      kind;
      logic                              status;
      logic [BYTE_W-1:0]                 buttons;
      logic [NUM_DIGITS-1:0][BYTE_W-1:0] digits;
   } cmd_entry_type;

   // returns {valid, segment pattern}
   function automatic logic [8:0] seg_lookup(input logic [7:0] ch);
      logic [7:0] idx;
      logic [8:0] r;
      idx = '0;
      r   = '0;
      if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
         idx = ch - CHAR_ZERO;
         r   = {1'b1, SEG_TABLE[idx[5:0]]};
      end else if (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) begin
         idx = ch - CHAR_UPPER_A + LETTER_BASE;
         r   = {1'b1, SEG_TABLE[idx[5:0]]};
      end else if (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z) begin
         idx = ch - CHAR_LOWER_A + LETTER_BASE;
         r   = {1'b1, SEG_TABLE[idx[5:0]]};
      end else if (ch == CHAR_SPACE) begin
         r = {1'b1, 8'h00};
      end
      return r;
   endfunction

endpackage

FILE: src/kdsl_front.sv
module kdsl_front (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_stall,
   input  logic [1:0]               req_opcode,
   input  logic [7:0]               req_rx_byte,
   input  logic [7:0]               req_text_char0,
   input  logic [7:0]               req_text_char1,
   input  logic [7:0]               req_text_char2,
   input  logic [7:0]               req_text_char3,
   input  logic [3:0]               req_text_length,
   input  logic [3:0]               req_dot_mask,
   input  logic [7:0]               button_event_code,
   input  logic [7:0]               unit_reset_code,
   input  logic                     queue_full,
   output logic                     push,
   output kdsl_pkg::cmd_entry_type  push_entry
);

   logic [2:0][7:0] hist_ff, hist_in;
   logic [7:0]      btn_ff, btn_in;
   logic [3:0][7:0] digits_ff, digits_in;
   logic [3:0][7:0] text;
   logic [3:0][7:0] pat;
   logic [3:0]      ok;
   logic [3:0]      dots;
   logic [8:0]      lut;
   logic            prefix_ok;
   logic            accept;

   assign req_stall = queue_full;
   assign accept    = req_valid && !queue_full;
   assign push      = accept;

   assign text[0] = req_text_char0;
   assign text[1] = req_text_char1;
   assign text[2] = req_text_char2;
   assign text[3] = req_text_char3;

   // segment lookup per digit; digit i shows character 3-i, padded with spaces
   always_comb begin
      for (int i = 0; i < 4; i++) begin
         lut = kdsl_pkg::seg_lookup((req_text_length > 4'(3 - i)) ?
                                    text[3 - i] : kdsl_pkg::CHAR_SPACE);
         ok[i]  = lut[8];
         pat[i] = lut[7:0];
      end
      dots = (req_text_length == kdsl_pkg::LEN_WITH_DOT) ? req_dot_mask : 4'h0;
   end

   always_comb begin
      hist_in   = hist_ff;
      btn_in    = btn_ff;
      digits_in = digits_ff;
      prefix_ok = 1'b1;
      push_entry.kind   = kdsl_pkg::CMD_NONE;
      push_entry.status = kdsl_pkg::STATUS_OK;

      unique case (req_opcode)
         kdsl_pkg::OP_RX_BYTE: begin
            hist_in = {req_rx_byte, hist_ff[2], hist_ff[1]};
            if (hist_in[0] == button_event_code && hist_in[1][7] && hist_in[2][7]) begin
               btn_in = ~{hist_in[2][3], hist_in[2][1], hist_in[2][2], hist_in[2][0],
                          hist_in[1][3:0]};
            end else if (hist_in[2] == unit_reset_code) begin
               push_entry.kind = kdsl_pkg::CMD_INIT;
            end
         end
         kdsl_pkg::OP_DISPLAY: begin
            if (req_text_length == 4'd0 || req_text_length > kdsl_pkg::LEN_MAX) begin
               push_entry.status = kdsl_pkg::STATUS_REJECT;
            end else begin
               // convert from the right; stop at the first bad character
               for (int i = 0; i < 4; i++) begin
                  prefix_ok = prefix_ok && ok[i];
                  if (prefix_ok) begin
                     digits_in[i] = pat[i] | (dots[i] ? kdsl_pkg::DOT_BIT : 8'h00);
                  end
               end
               if (prefix_ok) begin
                  push_entry.kind = kdsl_pkg::CMD_DISPLAY;
               end else begin
                  push_entry.status = kdsl_pkg::STATUS_REJECT;
               end
            end
         end
         kdsl_pkg::OP_INIT: begin
            push_entry.kind = kdsl_pkg::CMD_INIT;
         end
         default: begin
         end
      endcase

      push_entry.buttons = btn_in;
      push_entry.digits  = digits_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hist_ff   <= '0;
         btn_ff    <= '0;
         digits_ff <= '0;
      end else if (accept) begin
         hist_ff   <= hist_in;
         btn_ff    <= btn_in;
         digits_ff <= digits_in;
      end
   end

endmodule

FILE: src/kdsl_queue.sv
module kdsl_queue #(
   parameter int unsigned DEPTH = 2
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     push,
   input  kdsl_pkg::cmd_entry_type  push_entry,
   input  logic                     pop,
   output kdsl_pkg::cmd_entry_type  head,
   output logic                     empty,
   output logic                     full
);

   localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int unsigned CW = $clog2(DEPTH + 1);

   kdsl_pkg::cmd_entry_type mem_ff [DEPTH];
   logic [AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;

   assign empty = (count_ff == '0);
   assign full  = (count_ff == CW'(DEPTH));
   assign head  = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

FILE: src/kdsl_back.sv
module kdsl_back (
   input  logic                     clock,
   input  logic                     reset,
   input  kdsl_pkg::cmd_entry_type  head,
   input  logic                     empty,
   output logic                     pop,
   input  logic [7:0]               buttons_enable_code,
   input  logic [7:0]               display_user_code,
   input  logic [7:0]               display_set_code,
   output logic                     rsp_valid,
   input  logic                     rsp_stall,
   output logic [7:0]               rsp_send_byte,
   output logic                     rsp_send_valid,
   output logic                     rsp_last,
   output logic                     rsp_status,
   output logic [7:0]               rsp_buttons
);

   logic [2:0] step_ff, step_in;
   logic [2:0] byte_idx;
   logic       rsp_valid_ff;
   logic [7:0] send_byte_ff, send_byte_in;
   logic       send_valid_ff, send_valid_in;
   logic       last_ff, last_in;
   logic       status_ff;
   logic [7:0] buttons_ff;
   logic       advance;
   logic       load;

   assign advance = !rsp_valid_ff || !rsp_stall;
   assign load    = advance && !empty;

   // init sequence runs bytes 0..7, display command bytes 2..7
   assign byte_idx = (head.kind == kdsl_pkg::CMD_DISPLAY) ? step_ff + 3'd2 : step_ff;

   always_comb begin
      send_byte_in  = 8'h00;
      send_valid_in = 1'b1;
      last_in       = (byte_idx == 3'd7);
      unique case (byte_idx)
         3'd0:    send_byte_in = buttons_enable_code;
         3'd1:    send_byte_in = display_user_code;
         3'd2:    send_byte_in = display_set_code;
         3'd3:    send_byte_in = kdsl_pkg::DIGIT_ENABLE;
         default: send_byte_in = head.digits[byte_idx[1:0]];
      endcase
      if (head.kind == kdsl_pkg::CMD_NONE) begin
         send_byte_in  = 8'h00;
         send_valid_in = 1'b0;
         last_in       = 1'b1;
      end
      pop     = load && last_in;
      step_in = step_ff;
      if (load) begin
         step_in = last_in ? 3'd0 : step_ff + 3'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         step_ff <= step_in;
         if (advance) begin
            rsp_valid_ff <= !empty;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         send_byte_ff  <= send_byte_in;
         send_valid_ff <= send_valid_in;
         last_ff       <= last_in;
         status_ff     <= head.status;
         buttons_ff    <= head.buttons;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_send_byte  = send_byte_ff;
   assign rsp_send_valid = send_valid_ff;
   assign rsp_last       = last_ff;
   assign rsp_status     = status_ff;
   assign rsp_buttons    = buttons_ff;

endmodule

FILE: src/keypad_display_serial_link_unit.sv
// Host-side controller for a serial keypad/display unit.
// Request channel (req_valid/req_stall): opcode 0 delivers a byte received
// from the unit, opcode 1 writes up to four display characters, opcode 2
// reinitializes the unit. Each request yields 1, 6 or 8 response items on
// the rsp_valid/rsp_stall channel; rsp_last marks the final one, and
// rsp_send_valid tells whether rsp_send_byte goes out on the serial line.
// The front end classifies a request and updates the receive history,
// button state and digit patterns in the cycle it is taken; the command
// then sits in a small queue until the byte sequencer plays it out.
// A taken request goes into the command queue; the response register that
// drives rsp_valid then loads it from the queue head. req_stall rises only
// while the queue is full. Throughput: while rsp_stall is low, one response
// per cycle, and requests that produce one response can follow every cycle;
// a request occupies the sequencer for its 1, 6 or 8 items. When rsp_valid
// and rsp_stall are high, the response register holds its contents and the
// queue fills up behind it. Synchronous reset clears the history, buttons,
// digits and queue and restores the default command codes.
// csr_* writes set the command codes; write them only while idle.
module keypad_display_serial_link_unit #(
   parameter int unsigned QUEUE_DEPTH = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_write_en,
   input  logic [2:0]  csr_index,
   input  logic [7:0]  csr_wdata,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [7:0]  req_rx_byte,
   input  logic [7:0]  req_text_char0,
   input  logic [7:0]  req_text_char1,
   input  logic [7:0]  req_text_char2,
   input  logic [7:0]  req_text_char3,
   input  logic [3:0]  req_text_length,
   input  logic [3:0]  req_dot_mask,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [7:0]  rsp_send_byte,
   output logic        rsp_send_valid,
   output logic        rsp_last,
   output logic        rsp_status,
   output logic [7:0]  rsp_buttons
);

   logic [7:0] button_event_ff;
   logic [7:0] unit_reset_ff;
   logic [7:0] buttons_enable_ff;
   logic [7:0] display_user_ff;
   logic [7:0] display_set_ff;

   logic                    push;
   logic                    pop;
   logic                    empty;
   logic                    full;
   kdsl_pkg::cmd_entry_type push_entry;
   kdsl_pkg::cmd_entry_type head;

   always_ff @(posedge clock) begin
      if (reset) begin
         button_event_ff   <= kdsl_pkg::RESET_BUTTON_EVENT;
         unit_reset_ff     <= kdsl_pkg::RESET_UNIT_RESET;
         buttons_enable_ff <= kdsl_pkg::RESET_BUTTONS_ENABLE;
         display_user_ff   <= kdsl_pkg::RESET_DISPLAY_USER;
         display_set_ff    <= kdsl_pkg::RESET_DISPLAY_SET;
      end else if (csr_write_en) begin
         unique case (csr_index)
            kdsl_pkg::CSR_BUTTON_EVENT:   button_event_ff   <= csr_wdata;
            kdsl_pkg::CSR_UNIT_RESET:     unit_reset_ff     <= csr_wdata;
            kdsl_pkg::CSR_BUTTONS_ENABLE: buttons_enable_ff <= csr_wdata;
            kdsl_pkg::CSR_DISPLAY_USER:   display_user_ff   <= csr_wdata;
            kdsl_pkg::CSR_DISPLAY_SET:    display_set_ff    <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   kdsl_front u_front (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_rx_byte       (req_rx_byte),
      .req_text_char0    (req_text_char0),
      .req_text_char1    (req_text_char1),
      .req_text_char2    (req_text_char2),
      .req_text_char3    (req_text_char3),
      .req_text_length   (req_text_length),
      .req_dot_mask      (req_dot_mask),
      .button_event_code (button_event_ff),
      .unit_reset_code   (unit_reset_ff),
      .queue_full        (full),
      .push              (push),
      .push_entry        (push_entry)
   );

   kdsl_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .empty      (empty),
      .full       (full)
   );

   kdsl_back u_back (
      .clock               (clock),
      .reset               (reset),
      .head                (head),
      .empty               (empty),
      .pop                 (pop),
      .buttons_enable_code (buttons_enable_ff),
      .display_user_code   (display_user_ff),
      .display_set_code    (display_set_ff),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_send_byte       (rsp_send_byte),
      .rsp_send_valid      (rsp_send_valid),
      .rsp_last            (rsp_last),
      .rsp_status          (rsp_status),
      .rsp_buttons         (rsp_buttons)
   );

endmodule

FILE: tb/keypad_display_serial_link_unit_tb.sv
module keypad_display_serial_link_unit_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_LIMIT = 1000;
   localparam int HOLD_CYCLES    = 60;
   localparam int PHASE_ITEMS    = 29;

   localparam logic [1:0] OP_SPARE     = 2'd3;
   localparam logic [7:0] DIGIT_ON     = 8'h0F;
   localparam logic [7:0] DP_SEGMENT   = 8'h10;
   localparam logic [3:0] MAX_TEXT_LEN = 4'd5;

   // digits 0-9 then letters A-Z
   localparam logic [7:0] SEG_PATTERN [36] = '{
      8'he7, 8'h06, 8'hcb, 8'h8f, 8'h2e, 8'had, 8'hed, 8'h86, 8'hef, 8'haf,
      8'hee, 8'h6d, 8'h49, 8'h4f, 8'he9, 8'he8, 8'he5, 8'h6e, 8'h06, 8'h47,
      8'h6e, 8'h61, 8'he6, 8'h4c, 8'he7, 8'hea, 8'hae, 8'hee, 8'had, 8'h69,
      8'h45, 8'h67, 8'h67, 8'h6e, 8'h2f, 8'hcb
   };

   localparam logic [2:0] CODE_INDEX [5] = '{
      kdsl_pkg::CSR_BUTTON_EVENT, kdsl_pkg::CSR_UNIT_RESET, kdsl_pkg::CSR_BUTTONS_ENABLE,
      kdsl_pkg::CSR_DISPLAY_USER, kdsl_pkg::CSR_DISPLAY_SET
   };

   // text holds char0 (leftmost) in the top byte
   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  rx_byte;
      logic [31:0] text;
      logic [3:0]  length;
      logic [3:0]  dots;
   } link_req_type;

   typedef struct packed {
      logic [7:0] send_byte;
      logic       send_valid;
      logic       last;
      logic       status;
      logic [7:0] buttons;
   } link_rsp_type;

   typedef enum logic {ROW_REQ, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      bit           has_want;
      link_rsp_type want;
      link_req_type req;
      logic [2:0]   csr_idx;
      logic [7:0]   csr_val;
   } stim_row_type;

   localparam link_rsp_type RSP_QUIET       =
      '{8'h00, 1'b0, 1'b1, kdsl_pkg::STATUS_OK, 8'h00};
   localparam link_rsp_type RSP_REJECT      =
      '{8'h00, 1'b0, 1'b1, kdsl_pkg::STATUS_REJECT, 8'h00};
   localparam link_rsp_type RSP_ALL_PRESSED =
      '{8'h00, 1'b0, 1'b1, kdsl_pkg::STATUS_OK, 8'hFF};

   localparam stim_row_type DIRECTED [25] = '{
      '{ROW_REQ, 1'b1, RSP_QUIET,  '{kdsl_pkg::OP_RX_BYTE, 8'h00, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b1, RSP_QUIET,  '{OP_SPARE, 8'hFF, "    ", 4'd4, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b1, RSP_REJECT, '{kdsl_pkg::OP_DISPLAY, 8'h00, "8888", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b1, RSP_REJECT, '{kdsl_pkg::OP_DISPLAY, 8'h00, "8888", 4'd15, 4'hF}, '0, 8'h00},
      '{ROW_REQ, 1'b1, RSP_REJECT, '{kdsl_pkg::OP_DISPLAY, 8'h00, "8888", 4'd6, 4'h0}, '0, 8'h00},
      // rightmost digit gets written before the bad character is hit
      '{ROW_REQ, 1'b1, RSP_REJECT, '{kdsl_pkg::OP_DISPLAY, 8'h00, "12!4", 4'd4, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b1, RSP_REJECT, '{kdsl_pkg::OP_DISPLAY, 8'h00, 32'h0, 4'd4, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b1, RSP_REJECT, '{kdsl_pkg::OP_DISPLAY, 8'hFF, '1, 4'd5, 4'hF}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_DISPLAY, 8'h00, "09AZ", 4'd4, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_DISPLAY, 8'h00, "az m", 4'd5, 4'hF}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,
        '{kdsl_pkg::OP_DISPLAY, 8'h00, 32'h7AFFFFFF, 4'd1, 4'hF}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_DISPLAY, 8'h00, "7b!!", 4'd2, 4'h5}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_INIT, 8'h00, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,
        '{kdsl_pkg::OP_RX_BYTE, kdsl_pkg::RESET_UNIT_RESET, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,
        '{kdsl_pkg::OP_RX_BYTE, kdsl_pkg::RESET_BUTTON_EVENT, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_RX_BYTE, 8'h80, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b1, RSP_ALL_PRESSED,
        '{kdsl_pkg::OP_RX_BYTE, 8'h80, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,
        '{kdsl_pkg::OP_RX_BYTE, kdsl_pkg::RESET_BUTTON_EVENT, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_RX_BYTE, 8'hFF, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b1, RSP_QUIET,  '{kdsl_pkg::OP_RX_BYTE, 8'hFF, "    ", 4'd0, 4'h0}, '0, 8'h00},
      // reset code with bit 7 set, so it can close a button report
      '{ROW_CSR, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_RX_BYTE, 8'h00, "    ", 4'd0, 4'h0},
        kdsl_pkg::CSR_UNIT_RESET, 8'hC5},
      '{ROW_REQ, 1'b0, RSP_QUIET,
        '{kdsl_pkg::OP_RX_BYTE, kdsl_pkg::RESET_BUTTON_EVENT, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_RX_BYTE, 8'h80, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_RX_BYTE, 8'hC5, "    ", 4'd0, 4'h0}, '0, 8'h00},
      '{ROW_REQ, 1'b0, RSP_QUIET,  '{kdsl_pkg::OP_RX_BYTE, 8'hC5, "    ", 4'd0, 4'h0}, '0, 8'h00}
   };

   logic       clock;
   logic       reset;
   logic       csr_write_en;
   logic [2:0] csr_index;
   logic [7:0] csr_wdata;
   logic       req_valid;
   logic       req_stall;
   logic [1:0] req_opcode;
   logic [7:0] req_rx_byte;
   logic [7:0] req_text_char0;
   logic [7:0] req_text_char1;
   logic [7:0] req_text_char2;
   logic [7:0] req_text_char3;
   logic [3:0] req_text_length;
   logic [3:0] req_dot_mask;
   logic       rsp_valid;
   logic       rsp_stall;
   logic [7:0] rsp_send_byte;
   logic       rsp_send_valid;
   logic       rsp_last;
   logic       rsp_status;
   logic [7:0] rsp_buttons;

   // shadow of the block
   logic [7:0] link_code [5];
   logic [7:0] rx_hist [3];
   logic [7:0] digit_pat [4];
   logic [7:0] button_st;

   link_rsp_type pred_rsp [8];
   int           pred_count;
   link_rsp_type link_rsp_q [$];
   int           mismatch_count;
   int           send_idle_pct;
   int           rsp_stall_pct;
   int           hold_requests;

   keypad_display_serial_link_unit dut (
      .clock           (clock),
      .reset           (reset),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_opcode      (req_opcode),
      .req_rx_byte     (req_rx_byte),
      .req_text_char0  (req_text_char0),
      .req_text_char1  (req_text_char1),
      .req_text_char2  (req_text_char2),
      .req_text_char3  (req_text_char3),
      .req_text_length (req_text_length),
      .req_dot_mask    (req_dot_mask),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_send_byte   (rsp_send_byte),
      .rsp_send_valid  (rsp_send_valid),
      .rsp_last        (rsp_last),
      .rsp_status      (rsp_status),
      .rsp_buttons     (rsp_buttons)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   function automatic bit map_segment(input logic [7:0] ch, output logic [7:0] pat);
      logic [7:0] idx;
      pat = 8'h00;
      idx = 8'h00;
      if (ch >= "0" && ch <= "9") begin
         idx = ch - "0";
         pat = SEG_PATTERN[idx[5:0]];
      end else if (ch >= "A" && ch <= "Z") begin
         idx = ch - "A" + 8'd10;
         pat = SEG_PATTERN[idx[5:0]];
      end else if (ch >= "a" && ch <= "z") begin
         idx = ch - "a" + 8'd10;
         pat = SEG_PATTERN[idx[5:0]];
      end else if (ch != " ") begin
         return 1'b0;
      end
      return 1'b1;
   endfunction

   function automatic void add_pred(input logic [7:0] b, input logic v, input logic l,
                                    input logic s);
      pred_rsp[pred_count] = '{b, v, l, s, button_st};
      pred_count = pred_count + 1;
   endfunction

   // updates the shadow state and fills pred_rsp with the bytes one request sends
   function automatic void predict_link_response(input link_req_type r);
      logic [7:0] chr;
      logic [7:0] pat;
      logic [7:0] pressed;
      logic [3:0] dots;
      bit         start_init;
      bit         show;
      bit         reject;
      bit         ok;
      int         i;
      start_init = 1'b0;
      show       = 1'b0;
      reject     = 1'b0;
      pred_count = 0;
      case (r.opcode)
         kdsl_pkg::OP_RX_BYTE: begin
            rx_hist[0] = rx_hist[1];
            rx_hist[1] = rx_hist[2];
            rx_hist[2] = r.rx_byte;
            if (rx_hist[0] == link_code[kdsl_pkg::CSR_BUTTON_EVENT] &&
                rx_hist[1][7] && rx_hist[2][7]) begin
               // report is active low, second data byte is shuffled
               pressed = {rx_hist[2][3], rx_hist[2][1], rx_hist[2][2], rx_hist[2][0],
                          rx_hist[1][3:0]};
               button_st = ~pressed;
            end else if (rx_hist[2] == link_code[kdsl_pkg::CSR_UNIT_RESET]) begin
               start_init = 1'b1;
            end
         end
         kdsl_pkg::OP_DISPLAY: begin
            if (r.length == 4'd0 || r.length > MAX_TEXT_LEN) begin
               reject = 1'b1;
            end else begin
               dots = (r.length == MAX_TEXT_LEN) ? r.dots : 4'h0;
               ok   = 1'b1;
               // rightmost first; digits done before a bad character keep their update
               for (i = 0; i < 4 && ok; i++) begin
                  chr = ((3 - i) < int'(r.length)) ? r.text[8*i +: 8] : " ";
                  ok  = map_segment(chr, pat);
                  if (ok) begin
                     digit_pat[i] = dots[i] ? (pat | DP_SEGMENT) : pat;
                  end
               end
               show   = ok;
               reject = !ok;
            end
         end
         kdsl_pkg::OP_INIT: begin
            start_init = 1'b1;
         end
         default: ;
      endcase
      if (start_init) begin
         add_pred(link_code[kdsl_pkg::CSR_BUTTONS_ENABLE], 1'b1, 1'b0, kdsl_pkg::STATUS_OK);
         add_pred(link_code[kdsl_pkg::CSR_DISPLAY_USER], 1'b1, 1'b0, kdsl_pkg::STATUS_OK);
      end
      if (start_init || show) begin
         add_pred(link_code[kdsl_pkg::CSR_DISPLAY_SET], 1'b1, 1'b0, kdsl_pkg::STATUS_OK);
         add_pred(DIGIT_ON, 1'b1, 1'b0, kdsl_pkg::STATUS_OK);
         for (i = 0; i < 4; i++) begin
            add_pred(digit_pat[i], 1'b1, i == 3, kdsl_pkg::STATUS_OK);
         end
      end
      if (pred_count == 0) begin
         add_pred(8'h00, 1'b0, 1'b1,
                  reject ? kdsl_pkg::STATUS_REJECT : kdsl_pkg::STATUS_OK);
      end
   endfunction

   function automatic logic [7:0] pick_glyph();
      int g;
      g = $urandom_range(0, 62);
      if (g < 10) begin
         return 8'(g) + "0";
      end else if (g < 36) begin
         return 8'(g - 10) + "A";
      end else if (g < 62) begin
         return 8'(g - 36) + "a";
      end
      return " ";
   endfunction

   task automatic write_code(input logic [2:0] idx, input logic [7:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      link_code[idx] = val;
   endtask

   task automatic wait_for_responses();
      req_valid <= 1'b0;
      while (link_rsp_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic drive_request(input link_req_type r, input bit has_want,
                                input link_rsp_type want);
      int k;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_opcode      <= r.opcode;
      req_rx_byte     <= r.rx_byte;
      req_text_char0  <= r.text[31:24];
      req_text_char1  <= r.text[23:16];
      req_text_char2  <= r.text[15:8];
      req_text_char3  <= r.text[7:0];
      req_text_length <= r.length;
      req_dot_mask    <= r.dots;
      do @(posedge clock); while (req_stall);
      predict_link_response(r);
      if (has_want) begin
         link_rsp_q.push_back(want);
      end else begin
         for (k = 0; k < pred_count; k++) link_rsp_q.push_back(pred_rsp[k]);
      end
   endtask

   task automatic send_random_sequence(output int count);
      link_req_type r;
      int           pick;
      int           k;
      pick      = $urandom_range(0, 99);
      r.opcode  = kdsl_pkg::OP_RX_BYTE;
      r.rx_byte = 8'($urandom_range(0, 255));
      r.text    = $urandom;
      r.length  = 4'($urandom_range(0, 15));
      r.dots    = 4'($urandom_range(0, 15));
      count     = 1;
      if (pick < 35) begin
         // button report; a data byte sometimes lacks bit 7
         r.rx_byte = link_code[kdsl_pkg::CSR_BUTTON_EVENT];
         drive_request(r, 1'b0, RSP_QUIET);
         for (k = 0; k < 2; k++) begin
            r.rx_byte    = 8'($urandom_range(0, 255));
            r.rx_byte[7] = ($urandom_range(0, 9) != 0);
            drive_request(r, 1'b0, RSP_QUIET);
         end
         count = 3;
      end else if (pick < 48) begin
         r.rx_byte = link_code[kdsl_pkg::CSR_UNIT_RESET];
         drive_request(r, 1'b0, RSP_QUIET);
      end else if (pick < 80) begin
         r.opcode = kdsl_pkg::OP_DISPLAY;
         if ($urandom_range(0, 99) < 85) r.length = 4'($urandom_range(1, MAX_TEXT_LEN));
         for (k = 0; k < 4; k++) begin
            r.text[8*k +: 8] = ($urandom_range(0, 15) == 0) ? 8'($urandom) : pick_glyph();
         end
         drive_request(r, 1'b0, RSP_QUIET);
      end else if (pick < 90) begin
         r.opcode = kdsl_pkg::OP_INIT;
         drive_request(r, 1'b0, RSP_QUIET);
      end else begin
         if ($urandom_range(0, 4) == 0) r.opcode = OP_SPARE;
         drive_request(r, 1'b0, RSP_QUIET);
      end
   endtask

   initial begin : rsp_stall_gen
      int hold_left;
      int holds_done;
      hold_left  = 0;
      holds_done = 0;
      rsp_stall  = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests != holds_done) begin
            holds_done = hold_requests;
            hold_left  = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            rsp_stall <= ($urandom_range(0, 99) < rsp_stall_pct);
         end
      end
   end

   always @(posedge clock) begin : rsp_check
      link_rsp_type got;
      link_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         got = '{rsp_send_byte, rsp_send_valid, rsp_last, rsp_status, rsp_buttons};
         if (link_rsp_q.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
               $display("unexpected response: byte=%h send_valid=%b last=%b status=%b buttons=%h",
                        got.send_byte, got.send_valid, got.last, got.status, got.buttons);
            end
         end else begin
            want = link_rsp_q.pop_front();
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= 10) begin
                  $display("response mismatch at %0t:", $realtime);
                  $display("  expected byte=%h send_valid=%b last=%b status=%b buttons=%h",
                           want.send_byte, want.send_valid, want.last, want.status,
                           want.buttons);
                  $display("  actual   byte=%h send_valid=%b last=%b status=%b buttons=%h",
                           got.send_byte, got.send_valid, got.last, got.status, got.buttons);
               end
            end
         end
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
            quiet = 0;
         end else begin
            quiet++;
         end
      end
      $display("Mismatches found");
      $finish;
   end

   initial begin : stimulus
      int         phase;
      int         sent;
      int         burst;
      int         k;
      bit         paused;
      logic [7:0] code_val;
      reset           = 1'b1;
      csr_write_en    = 1'b0;
      csr_index       = '0;
      csr_wdata       = '0;
      req_valid       = 1'b0;
      req_opcode      = kdsl_pkg::OP_RX_BYTE;
      req_rx_byte     = '0;
      req_text_char0  = '0;
      req_text_char1  = '0;
      req_text_char2  = '0;
      req_text_char3  = '0;
      req_text_length = '0;
      req_dot_mask    = '0;
      mismatch_count  = 0;
      send_idle_pct   = 0;
      rsp_stall_pct   = 0;
      hold_requests   = 0;
      link_code[kdsl_pkg::CSR_BUTTON_EVENT]   = kdsl_pkg::RESET_BUTTON_EVENT;
      link_code[kdsl_pkg::CSR_UNIT_RESET]     = kdsl_pkg::RESET_UNIT_RESET;
      link_code[kdsl_pkg::CSR_BUTTONS_ENABLE] = kdsl_pkg::RESET_BUTTONS_ENABLE;
      link_code[kdsl_pkg::CSR_DISPLAY_USER]   = kdsl_pkg::RESET_DISPLAY_USER;
      link_code[kdsl_pkg::CSR_DISPLAY_SET]    = kdsl_pkg::RESET_DISPLAY_SET;
      for (k = 0; k < 3; k++) rx_hist[k] = 8'h00;
      for (k = 0; k < 4; k++) digit_pat[k] = 8'h00;
      button_st = 8'h00;

      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (DIRECTED[n]) begin
         if (DIRECTED[n].kind == ROW_CSR) begin
            wait_for_responses();
            write_code(DIRECTED[n].csr_idx, DIRECTED[n].csr_val);
         end else begin
            drive_request(DIRECTED[n].req, DIRECTED[n].has_want, DIRECTED[n].want);
         end
      end

      for (phase = 0; phase < 3; phase++) begin
         wait_for_responses();
         send_idle_pct = (phase == 0) ? 30 : (phase == 1) ? 82 : 0;
         rsp_stall_pct = (phase == 0) ? 82 : (phase == 1) ? 30 : 0;
         foreach (CODE_INDEX[c]) begin
            code_val = (phase == 0) ? 8'h00 : (phase == 1) ? 8'hFF : 8'($urandom);
            write_code(CODE_INDEX[c], code_val);
         end
         sent   = 0;
         paused = 1'b0;
         // long hold-off on the response side while requests keep coming
         if (phase == 2) hold_requests++;
         while (sent < PHASE_ITEMS) begin
            send_random_sequence(burst);
            sent += burst;
            if (phase == 2 && sent >= 14 && !paused) begin
               paused = 1'b1;
               wait_for_responses();
            end
         end
      end

      wait_for_responses();
      repeat (20) @(posedge clock);
      mismatch_count += link_rsp_q.size();
      if (mismatch_count == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

endmodule

FILE: keypad_display_serial_link_unit.f
src/kdsl_pkg.sv
src/kdsl_front.sv
src/kdsl_queue.sv
src/kdsl_back.sv
src/keypad_display_serial_link_unit.sv
tb/keypad_display_serial_link_unit_tb.sv
